### src/plv_pkg.sv
// Shared types, constants and helpers for the proximity vertex lighting block.
// No dependencies; imported by every module of the block.
`default_nettype none

package plv_pkg;

  // Default grid and chunk sizes (handed down as top-level parameters)
  localparam int WORLD_COLS_DEF           = 16;
  localparam int WORLD_ROWS_DEF           = 16;
  localparam int MAX_LIGHTS_PER_CHUNK_DEF = 4;

  // Fixed field widths
  localparam int POS_W    = 20;
  localparam int LPOS_W   = 3 * POS_W;
  localparam int DIST_W   = 42;
  localparam int COLOR_W  = 16;
  localparam int NIB_W    = 4;
  localparam int OP_W     = 2;
  localparam int CHUNK_W  = 4;
  localparam int SLOT_W   = 2;
  localparam int LCOUNT_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIST_W;

  typedef enum logic [OP_W-1:0] {
    OP_LIGHT_POS   = 2'd0,
    OP_CHUNK_COUNT = 2'd1,
    OP_VERTEX      = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REACH_SQ = 1'd0,
    REG_FALLOFF  = 1'd1
  } cfg_reg_t;

  // Subtract falloff from a color nibble, saturating at zero
  function automatic logic [NIB_W-1:0] reduce_nib(input logic [NIB_W-1:0] nib,
                                                  input logic [NIB_W-1:0] fall);
    logic [NIB_W-1:0] res;
    res = (nib > fall) ? (nib - fall) : '0;
    return res;
  endfunction

endpackage

`default_nettype wire

### src/plv_dist.sv
// Pipelined squared-distance unit: one light against the vertex per cycle.
// Three stages (abs diff, square, sum and compare). Depends on plv_pkg.
`default_nettype none

module plv_dist
  import plv_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  input  wire logic [LPOS_W-1:0]        light,
  input  wire logic signed [POS_W-1:0]  vtx_x,
  input  wire logic signed [POS_W-1:0]  vtx_y,
  input  wire logic signed [POS_W-1:0]  vtx_z,
  input  wire logic [DIST_W-1:0]        thresh,
  output logic                          hit_vld,
  output logic                          hit,
  output logic                          busy
);

  localparam int SQ_W = 2 * POS_W;

  logic [POS_W:0]   dx, dy, dz, ndx, ndy, ndz;
  logic [POS_W-1:0] ax_r, ay_r, az_r, ax_nxt, ay_nxt, az_nxt;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0] sum;
  logic             s1_vld_r, s2_vld_r, hit_vld_r, hit_r;

  // light word packs x in the top bits, then y, then z
  always_comb begin
    dx  = {light[3*POS_W-1], light[3*POS_W-1:2*POS_W]} - {vtx_x[POS_W-1], vtx_x};
    dy  = {light[2*POS_W-1], light[2*POS_W-1:POS_W]} - {vtx_y[POS_W-1], vtx_y};
    dz  = {light[POS_W-1], light[POS_W-1:0]} - {vtx_z[POS_W-1], vtx_z};
    ndx = -dx;
    ndy = -dy;
    ndz = -dz;
    ax_nxt = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
    ay_nxt = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
    az_nxt = dz[POS_W] ? ndz[POS_W-1:0] : dz[POS_W-1:0];
    sum = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    az_r  <= az_nxt;
    sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sqz_r <= SQ_W'(az_r) * SQ_W'(az_r);
    hit_r <= (sum < thresh);
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      hit_vld_r <= s2_vld_r;
    end
  end

  assign hit_vld = hit_vld_r;
  assign hit     = hit_r;
  assign busy    = s1_vld_r | s2_vld_r | hit_vld_r;

endmodule

`default_nettype wire

### src/proximity_vertex_lighting_top.sv
// Top level of the proximity vertex lighting block: sequencer, chunk count and
// light position memories. Depends on plv_pkg and plv_dist.
//
// Usage:
//   Input channel (in_*): valid/stall. op 0 writes a light position into a
//   chunk slot, op 1 writes a chunk's light count, op 2 lights a vertex.
//   Loads give no result. A vertex item in the grid returns one result
//   on the out_* channel: the color with falloff applied and the lit flag.
//   Configuration (cfg_*): write the squared reach (index 0) or falloff
//   (index 1) while the block is idle.
//   For a vertex the sequencer walks the up to nine in-grid chunks of the 3x3
//   block around the vertex chunk. An out-of-grid neighbor is skipped in
//   S_NBR; an in-grid one passes S_NBR, S_CNT, then S_LIGHT once per light it
//   holds (one light memory read per cycle into the distance unit). S_DRAIN
//   then waits for the distance unit to empty and the output register to free.
//   The block takes no item while a vertex runs.
//   After reset the chunk counts are cleared, one chunk per cycle, while in_stall
//   is high.
//   A stalled result is held in the output register; the next item is still
//   taken, and a vertex that finishes meanwhile waits for the register.
`default_nettype none

module proximity_vertex_lighting_top
  import plv_pkg::*;
#(
  parameter int WORLD_COLS           = WORLD_COLS_DEF,
  parameter int WORLD_ROWS           = WORLD_ROWS_DEF,
  parameter int MAX_LIGHTS_PER_CHUNK = MAX_LIGHTS_PER_CHUNK_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [CHUNK_W-1:0]       in_chunk_col,
  input  wire logic [CHUNK_W-1:0]       in_chunk_row,
  input  wire logic [SLOT_W-1:0]        in_slot,
  input  wire logic [LCOUNT_W-1:0]      in_light_count,
  input  wire logic signed [POS_W-1:0]  in_pos_x,
  input  wire logic signed [POS_W-1:0]  in_pos_y,
  input  wire logic signed [POS_W-1:0]  in_pos_z,
  input  wire logic [COLOR_W-1:0]       in_color_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [COLOR_W-1:0]            out_color_out,
  output logic                          out_lit,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CHUNKS = WORLD_COLS * WORLD_ROWS;
  localparam int LIGHTS = CHUNKS * MAX_LIGHTS_PER_CHUNK;
  localparam int CIW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int LIW    = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
  localparam int SW     = (MAX_LIGHTS_PER_CHUNK > 1) ? $clog2(MAX_LIGHTS_PER_CHUNK) : 1;
  localparam int CW     = $clog2(MAX_LIGHTS_PER_CHUNK + 1);
  localparam int NW     = CHUNK_W + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_NBR   = 6'b000100,
    S_CNT   = 6'b001000,
    S_LIGHT = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIST_W-1:0] reach_sq_r;
  logic [NIB_W-1:0]  falloff_r;

  // vertex context
  logic signed [POS_W-1:0] vx_r, vy_r, vz_r;
  logic [COLOR_W-1:0]      color_r;
  logic [CHUNK_W-1:0]      col_r, row_r;
  logic                    lit_r, lit_nxt;
  logic                    vtx_load;

  // neighbor walk
  logic [1:0]    co_r, co_nxt, ro_r, ro_nxt;
  logic [CIW-1:0] nchunk_r, nchunk_nxt;
  logic [CW-1:0] ncnt_r, ncnt_nxt;
  logic [SW-1:0] li_r, li_nxt;
  logic [CIW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] ncp, nrp;
  logic          nb_in;
  logic [31:0]   nb_chunk_w, lm_raddr_w, ld_chunk_w, lm_waddr_w;

  // memories
  logic [CW-1:0]     cnt_mem [CHUNKS];
  logic [CW-1:0]     cnt_rd_r;
  logic              cnt_we;
  logic [CIW-1:0]    cnt_waddr;
  logic [CW-1:0]     cnt_wdata, cnt_ld;
  logic [LPOS_W-1:0] lmem [LIGHTS];
  logic [LPOS_W-1:0] lm_rd_r;
  logic              lm_we;
  logic              p0_vld_r;

  logic in_accept, in_grid, done;
  logic dist_hit_vld, dist_hit, dist_busy;

  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic                 out_lit_r;
  logic [NIB_W-1:0]     r_n, b_n, g_n;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_grid   = (32'(in_chunk_col) < 32'(WORLD_COLS)) &&
                     (32'(in_chunk_row) < 32'(WORLD_ROWS));

  // load addressing
  assign ld_chunk_w = 32'(in_chunk_col) * 32'(WORLD_ROWS) + 32'(in_chunk_row);
  assign lm_waddr_w = ld_chunk_w * 32'(MAX_LIGHTS_PER_CHUNK) + 32'(in_slot);
  assign cnt_ld = (32'(in_light_count) > 32'(MAX_LIGHTS_PER_CHUNK)) ?
                  CW'(MAX_LIGHTS_PER_CHUNK) : CW'(in_light_count);

  assign lm_we = in_accept && in_grid && (op_t'(in_op) == OP_LIGHT_POS) &&
                 (32'(in_slot) < 32'(MAX_LIGHTS_PER_CHUNK));
  assign vtx_load = in_accept && in_grid && (op_t'(in_op) == OP_VERTEX);

  always_comb begin
    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = in_accept && in_grid && (op_t'(in_op) == OP_CHUNK_COUNT);
      cnt_waddr = ld_chunk_w[CIW-1:0];
      cnt_wdata = cnt_ld;
    end
  end

  // neighbor chunk: offsets 0..2 stand for -1..+1
  assign ncp   = NW'(col_r) + NW'(co_r);
  assign nrp   = NW'(row_r) + NW'(ro_r);
  assign nb_in = (ncp != '0) && (nrp != '0) &&
                 (32'(ncp) <= 32'(WORLD_COLS)) && (32'(nrp) <= 32'(WORLD_ROWS));
  assign nb_chunk_w = 32'(ncp - NW'(1)) * 32'(WORLD_ROWS) + 32'(nrp - NW'(1));
  assign lm_raddr_w = 32'(nchunk_r) * 32'(MAX_LIGHTS_PER_CHUNK) + 32'(li_r);

  assign done = (state_r == S_DRAIN) && !p0_vld_r && !dist_busy &&
                (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    co_nxt     = co_r;
    ro_nxt     = ro_r;
    nchunk_nxt = nchunk_r;
    ncnt_nxt   = ncnt_r;
    li_nxt     = li_r;
    clr_nxt    = clr_r;
    lit_nxt    = lit_r | (dist_hit_vld & dist_hit);
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + CIW'(1);
        if (clr_r == CIW'(CHUNKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (vtx_load) begin
          co_nxt    = 2'd0;
          ro_nxt    = 2'd0;
          lit_nxt   = 1'b0;
          state_nxt = S_NBR;
        end
      end
      S_NBR: begin
        if (nb_in) begin
          nchunk_nxt = nb_chunk_w[CIW-1:0];
          state_nxt  = S_CNT;
        end else begin
          state_nxt = (co_r == 2'd2 && ro_r == 2'd2) ? S_DRAIN : S_NBR;
          ro_nxt    = (ro_r == 2'd2) ? 2'd0 : ro_r + 2'd1;
          co_nxt    = (ro_r == 2'd2) ? co_r + 2'd1 : co_r;
        end
      end
      S_CNT: begin
        ncnt_nxt = cnt_rd_r;
        li_nxt   = '0;
        if (cnt_rd_r != '0) begin
          state_nxt = S_LIGHT;
        end else begin
          state_nxt = (co_r == 2'd2 && ro_r == 2'd2) ? S_DRAIN : S_NBR;
          ro_nxt    = (ro_r == 2'd2) ? 2'd0 : ro_r + 2'd1;
          co_nxt    = (ro_r == 2'd2) ? co_r + 2'd1 : co_r;
        end
      end
      S_LIGHT: begin
        li_nxt = li_r + SW'(1);
        if (CW'(li_r) + CW'(1) == ncnt_r) begin
          state_nxt = (co_r == 2'd2 && ro_r == 2'd2) ? S_DRAIN : S_NBR;
          ro_nxt    = (ro_r == 2'd2) ? 2'd0 : ro_r + 2'd1;
          co_nxt    = (ro_r == 2'd2) ? co_r + 2'd1 : co_r;
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[nb_chunk_w[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[lm_waddr_w[LIW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    end
    lm_rd_r <= lmem[lm_raddr_w[LIW-1:0]];
  end

  plv_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p0_vld_r),
    .light   (lm_rd_r),
    .vtx_x   (vx_r),
    .vtx_y   (vy_r),
    .vtx_z   (vz_r),
    .thresh  (reach_sq_r),
    .hit_vld (dist_hit_vld),
    .hit     (dist_hit),
    .busy    (dist_busy)
  );

  // color: red 3:0, blue 11:8, green 15:12; blue always dimmed
  assign r_n = lit_r ? color_r[3:0] : reduce_nib(color_r[3:0], falloff_r);
  assign b_n = reduce_nib(color_r[11:8], falloff_r);
  assign g_n = lit_r ? color_r[15:12] : reduce_nib(color_r[15:12], falloff_r);

  always_ff @(posedge clk) begin
    co_r     <= co_nxt;
    ro_r     <= ro_nxt;
    nchunk_r <= nchunk_nxt;
    ncnt_r   <= ncnt_nxt;
    li_r     <= li_nxt;
    lit_r    <= lit_nxt;
    if (vtx_load) begin
      vx_r    <= in_pos_x;
      vy_r    <= in_pos_y;
      vz_r    <= in_pos_z;
      color_r <= in_color_in;
      col_r   <= in_chunk_col;
      row_r   <= in_chunk_row;
    end
    if (done) begin
      out_color_r <= {g_n, b_n, NIB_W'(0), r_n};
      out_lit_r   <= lit_r;
    end
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      p0_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      reach_sq_r  <= '0;
      falloff_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      p0_vld_r <= (state_r == S_LIGHT);
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_REACH_SQ: reach_sq_r <= cfg_wdata;
          REG_FALLOFF:  falloff_r  <= cfg_wdata[NIB_W-1:0];
          default:      falloff_r  <= falloff_r;
        endcase
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_color_out = out_color_r;
  assign out_lit       = out_lit_r;

endmodule

`default_nettype wire

### dv/tb_proximity_vertex_lighting_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for proximity_vertex_lighting_top: a directed table, then random
// light loads and vertex items, all checked against a lighting predictor kept in the bench.
// Depends on plv_pkg and the block's RTL.

module tb_proximity_vertex_lighting_top;
  import plv_pkg::*;

  localparam int COLS          = WORLD_COLS_DEF;
  localparam int ROWS          = WORLD_ROWS_DEF;
  localparam int LIGHTS        = MAX_LIGHTS_PER_CHUNK_DEF;
  localparam int NCHUNK        = COLS * ROWS;
  localparam int COUNT_TOP     = (1 << LCOUNT_W) - 1;
  localparam int PMIN          = -(1 << (POS_W - 1));
  localparam int PMAX          = (1 << (POS_W - 1)) - 1;
  localparam int SETTLE_CYCLES = 80;      // longest vertex walk plus margin
  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 115;
  localparam int MAX_PRINTS    = 40;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [NIB_W-1:0]  FALL_MAX  = '1;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [CHUNK_W-1:0]      col;
    logic [CHUNK_W-1:0]      row;
    logic [SLOT_W-1:0]       slot;
    logic [LCOUNT_W-1:0]     count;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [COLOR_W-1:0]      color;
  } vtx_item_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               lit;
  } shade_t;

  typedef enum logic [1:0] {ROW_SEND, ROW_SEND_TYPED, ROW_REGS} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    vtx_item_t         item;
    shade_t            shade;
    logic [DIST_W-1:0] reach;
    logic [NIB_W-1:0]  fall;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op = '0;
  logic [CHUNK_W-1:0]      in_chunk_col = '0;
  logic [CHUNK_W-1:0]      in_chunk_row = '0;
  logic [SLOT_W-1:0]       in_slot = '0;
  logic [LCOUNT_W-1:0]     in_light_count = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic [COLOR_W-1:0]      in_color_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [COLOR_W-1:0]      out_color_out;
  logic                    out_lit;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // predictor state
  logic signed [POS_W-1:0] light_x [NCHUNK*LIGHTS];
  logic signed [POS_W-1:0] light_y [NCHUNK*LIGHTS];
  logic signed [POS_W-1:0] light_z [NCHUNK*LIGHTS];
  bit                      pos_written [NCHUNK*LIGHTS];
  bit [LCOUNT_W-1:0]       lights_in_chunk [NCHUNK];
  bit [DIST_W-1:0]         cur_dist;
  bit [NIB_W-1:0]          cur_fall;
  shade_t                  pending_shades[$];
  dir_row_t                dir_table[$];

  int  n_errors, n_results, n_vertices, n_lit, n_loads, n_ignored, n_settings;
  int  cycle_count;
  int  burst_left, hot_col, hot_row;
  int  hold_left, run_left;
  bit  want_hold, hold_done;

  proximity_vertex_lighting_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_chunk_col   (in_chunk_col),
    .in_chunk_row   (in_chunk_row),
    .in_slot        (in_slot),
    .in_light_count (in_light_count),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_color_in    (in_color_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_color_out  (out_color_out),
    .out_lit        (out_lit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_shades.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("%0t MISMATCH %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned sq_gap(logic signed [POS_W-1:0] a,
                                             logic signed [POS_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // any light in the in-grid 3x3 block around the vertex chunk closer than the threshold
  function automatic bit vertex_near_light(int col, int row, logic signed [POS_W-1:0] x,
                                           logic signed [POS_W-1:0] y,
                                           logic signed [POS_W-1:0] z);
    int c, r, ch, idx;
    longint unsigned d2;
    for (int dc = -1; dc <= 1; dc++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        c = col + dc;
        r = row + dr;
        if (c < 0 || c >= COLS || r < 0 || r >= ROWS) continue;
        ch = c * ROWS + r;
        for (int s = 0; s < lights_in_chunk[ch]; s++) begin
          idx = ch * LIGHTS + s;
          d2 = sq_gap(light_x[idx], x) + sq_gap(light_y[idx], y) + sq_gap(light_z[idx], z);
          if (d2 < cur_dist) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_item(vtx_item_t it);
    int ch;
    bit lit;
    logic [NIB_W-1:0] r, b, g;
    shade_t sh;
    ch = int'(it.col) * ROWS + int'(it.row);
    if (it.col >= COLS || it.row >= ROWS) begin
      n_ignored++;
      return;
    end
    case (it.op)
      OP_LIGHT_POS: begin
        n_loads++;
        if (it.slot < LIGHTS) begin
          light_x[ch*LIGHTS + it.slot] = it.x;
          light_y[ch*LIGHTS + it.slot] = it.y;
          light_z[ch*LIGHTS + it.slot] = it.z;
          pos_written[ch*LIGHTS + it.slot] = 1'b1;
        end
      end
      OP_CHUNK_COUNT: begin
        n_loads++;
        lights_in_chunk[ch] = (it.count > LIGHTS) ? LCOUNT_W'(LIGHTS) : it.count;
      end
      OP_VERTEX: begin
        lit = vertex_near_light(it.col, it.row, it.x, it.y, it.z);
        r = it.color[3:0];
        b = it.color[11:8];
        g = it.color[15:12];
        b = (b > cur_fall) ? b - cur_fall : '0;
        if (!lit) begin
          r = (r > cur_fall) ? r - cur_fall : '0;
          g = (g > cur_fall) ? g - cur_fall : '0;
        end
        sh.color = {g, b, {NIB_W{1'b0}}, r};
        sh.lit = lit;
        pending_shades.push_back(sh);
        n_vertices++;
        if (lit) n_lit++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    shade_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_shades.size() == 0) begin
        report_mismatch($sformatf("result %0d: color %h lit %b with no vertex pending",
                                  n_results, out_color_out, out_lit));
      end else begin
        want = pending_shades.pop_front();
        if (out_color_out !== want.color)
          report_mismatch($sformatf("result %0d: color_out %h, expected %h", n_results,
                                    out_color_out, want.color));
        if (out_lit !== want.lit)
          report_mismatch($sformatf("result %0d: lit %b, expected %b", n_results, out_lit,
                                    want.lit));
      end
    end
  end

  // receiver stalls: short and long stretches, quiet runs, one long hold-off on request
  always @(posedge clk) begin
    int pick;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 6);
      end else if (pick < 55) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(20, 80);
      end else if (pick < 93) begin
        out_stall <= 1'b1;
        run_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        run_left = $urandom_range(8, 40);
      end
    end
  end

  // ---------------------------------------------------------------- input side

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(vtx_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_chunk_col   <= it.col;
    in_chunk_row   <= it.row;
    in_slot        <= it.slot;
    in_light_count <= it.count;
    in_pos_x       <= it.x;
    in_pos_y       <= it.y;
    in_pos_z       <= it.z;
    in_color_in    <= it.color;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer(vtx_item_t it);
    send_item(it, pick_gap());
    apply_item(it);
  endtask

  // sender waits for every pending result, then for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_regs(logic [DIST_W-1:0] d, logic [NIB_W-1:0] f);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_REACH_SQ;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= REG_FALLOFF;
    cfg_wdata <= CFG_DATA_W'(f);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_dist = d;
    cur_fall = f;
    n_settings++;
  endtask

  function automatic vtx_item_t rand_item();
    vtx_item_t it;
    it.op    = OP_W'($urandom);
    it.col   = CHUNK_W'($urandom);
    it.row   = CHUNK_W'($urandom);
    it.slot  = SLOT_W'($urandom);
    it.count = LCOUNT_W'($urandom);
    it.x     = POS_W'($urandom);
    it.y     = POS_W'($urandom);
    it.z     = POS_W'($urandom);
    it.color = COLOR_W'($urandom);
    return it;
  endfunction

  function automatic int jitter(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic int near(int c, int lim);
    int v;
    v = c + int'($urandom_range(0, 2)) - 1;
    return (v < 0) ? 0 : ((v >= lim) ? lim - 1 : v);
  endfunction

  // well-formed chunk load: k clustered light positions, then the count
  task automatic populate_chunk(output int n);
    vtx_item_t it;
    int k, spread;
    logic signed [POS_W-1:0] cx, cy, cz;
    n = 0;
    hot_col = $urandom_range(0, COLS - 1);
    hot_row = $urandom_range(0, ROWS - 1);
    k = $urandom_range(1, LIGHTS);
    cx = POS_W'($urandom);
    cy = POS_W'($urandom);
    cz = POS_W'($urandom);
    spread = (1 << $urandom_range(0, POS_W - 1)) - 1;
    for (int s = 0; s < k; s++) begin
      it = rand_item();
      it.op   = OP_LIGHT_POS;
      it.col  = CHUNK_W'(hot_col);
      it.row  = CHUNK_W'(hot_row);
      it.slot = SLOT_W'(s);
      it.x    = cx + POS_W'(jitter(spread));
      it.y    = cy + POS_W'(jitter(spread));
      it.z    = cz + POS_W'(jitter(spread));
      offer(it);
      n++;
    end
    it = rand_item();
    it.op    = OP_CHUNK_COUNT;
    it.col   = CHUNK_W'(hot_col);
    it.row   = CHUNK_W'(hot_row);
    it.count = LCOUNT_W'((k == LIGHTS) ? $urandom_range(LIGHTS, COUNT_TOP) : k);
    offer(it);
    n++;
  endtask

  // count write with random value; slots it exposes get a position first
  task automatic write_count(output int n);
    vtx_item_t it, cnt_item;
    int ch, used;
    n = 0;
    cnt_item = rand_item();
    cnt_item.op = OP_CHUNK_COUNT;
    ch = int'(cnt_item.col) * ROWS + int'(cnt_item.row);
    used = (cnt_item.count > LIGHTS) ? LIGHTS : cnt_item.count;
    for (int s = 0; s < used; s++) begin
      if (!pos_written[ch*LIGHTS + s]) begin
        it = rand_item();
        it.op   = OP_LIGHT_POS;
        it.col  = cnt_item.col;
        it.row  = cnt_item.row;
        it.slot = SLOT_W'(s);
        offer(it);
        n++;
      end
    end
    offer(cnt_item);
    n++;
  endtask

  // mostly aimed close to a light of the last loaded chunk, at a random scale
  task automatic send_vertex();
    vtx_item_t it;
    int ch, idx, spread;
    it = rand_item();
    it.op = OP_VERTEX;
    if ($urandom_range(0, 99) < 70) begin
      it.col = CHUNK_W'(near(hot_col, COLS));
      it.row = CHUNK_W'(near(hot_row, ROWS));
      ch = hot_col * ROWS + hot_row;
      if (lights_in_chunk[ch] != 0) begin
        idx = ch * LIGHTS + $urandom_range(0, lights_in_chunk[ch] - 1);
        spread = (1 << $urandom_range(0, POS_W - 1)) - 1;
        it.x = light_x[idx] + POS_W'(jitter(spread));
        it.y = light_y[idx] + POS_W'(jitter(spread));
        it.z = light_z[idx] + POS_W'(jitter(spread));
      end
    end
    offer(it);
  endtask

  task automatic random_phase(int target);
    vtx_item_t it;
    int sent, n, pick;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      n = 1;
      if (pick < 10) begin
        populate_chunk(n);
      end else if (pick < 20) begin
        it = rand_item();
        it.op = OP_LIGHT_POS;
        offer(it);
      end else if (pick < 28) begin
        write_count(n);
      end else if (pick < 32) begin
        it = rand_item();
        it.op = OP_UNUSED;
        offer(it);
        n = 0;
      end else begin
        send_vertex();
      end
      sent += n;
    end
  endtask

  // ---------------------------------------------------------------- directed table

  function automatic vtx_item_t mk(logic [OP_W-1:0] op, int col, int row, int slot, int cnt,
                                   int x, int y, int z, int color);
    vtx_item_t it;
    it.op    = op;
    it.col   = CHUNK_W'(col);
    it.row   = CHUNK_W'(row);
    it.slot  = SLOT_W'(slot);
    it.count = LCOUNT_W'(cnt);
    it.x     = POS_W'(x);
    it.y     = POS_W'(y);
    it.z     = POS_W'(z);
    it.color = COLOR_W'(color);
    return it;
  endfunction

  function automatic void tab_send(vtx_item_t it);
    dir_row_t r;
    r.kind = ROW_SEND;
    r.item = it;
    dir_table.push_back(r);
  endfunction

  function automatic void tab_typed(vtx_item_t it, logic [COLOR_W-1:0] c, logic l);
    dir_row_t r;
    r.kind        = ROW_SEND_TYPED;
    r.item        = it;
    r.shade.color = c;
    r.shade.lit   = l;
    dir_table.push_back(r);
  endfunction

  function automatic void tab_regs(logic [DIST_W-1:0] d, logic [NIB_W-1:0] f);
    dir_row_t r;
    r.kind  = ROW_REGS;
    r.reach = d;
    r.fall  = f;
    dir_table.push_back(r);
  endfunction

  initial begin
    // registers at reset: zero threshold, zero falloff
    tab_typed(mk(OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, 'hFFFF), 16'hFF0F, 1'b0);
    tab_send(mk(OP_UNUSED, 15, 15, 3, 7, PMAX, PMIN, -1, 'hFFFF));
    tab_regs(DIST_MAX, FALL_MAX);
    tab_typed(mk(OP_VERTEX, 15, 15, 3, 7, PMAX, PMAX, PMAX, 'hFFFF), 16'h0000, 1'b0);
    tab_send(mk(OP_LIGHT_POS, 0, 0, 0, 0, PMIN, PMIN, PMIN, 'h0000));
    tab_send(mk(OP_LIGHT_POS, 0, 0, 1, 0, 0, 0, 0, 'h0000));
    tab_send(mk(OP_LIGHT_POS, 0, 0, 2, 0, 1, -1, 1, 'h0000));
    tab_send(mk(OP_LIGHT_POS, 0, 0, 3, 0, PMAX, PMAX, PMAX, 'h0000));
    tab_send(mk(OP_CHUNK_COUNT, 0, 0, 0, COUNT_TOP, 0, 0, 0, 'h0000));  // clamps to four
    tab_typed(mk(OP_VERTEX, 0, 0, 0, 0, PMAX, PMAX, PMAX, 'hFFFF), 16'hF00F, 1'b1);
    tab_send(mk(OP_VERTEX, 1, 1, 0, 0, PMIN, PMIN, PMIN, 'hA5C3));
    tab_typed(mk(OP_VERTEX, 2, 2, 0, 0, 0, 0, 0, 'h1234), 16'h0000, 1'b0);
    // threshold of one: only an exact hit counts
    tab_regs(1, 7);
    tab_send(mk(OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, 'h8F78));
    tab_send(mk(OP_VERTEX, 0, 1, 0, 0, 1, 0, 0, 'hFFFF));
    tab_send(mk(OP_LIGHT_POS, 15, 15, 0, 0, PMAX, PMIN, 0, 'h0000));
    tab_send(mk(OP_CHUNK_COUNT, 15, 15, 0, 1, 0, 0, 0, 'h0000));
    tab_send(mk(OP_VERTEX, 14, 15, 0, 0, PMAX, PMIN, 0, 'h7777));
    tab_send(mk(OP_VERTEX, 15, 0, 0, 0, 0, 0, 0, 'hFFFF));
    tab_send(mk(OP_CHUNK_COUNT, 0, 0, 0, 0, 0, 0, 0, 'h0000));
    tab_send(mk(OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, 'hFFFF));
    tab_send(mk(OP_CHUNK_COUNT, 0, 0, 0, LIGHTS, 0, 0, 0, 'h0000));
    // zero threshold: nothing is ever lit
    tab_regs('0, 3);
    tab_typed(mk(OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, 'hFFFF), 16'hCC0C, 1'b0);
    tab_send(mk(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 'h0000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      case (dir_table[i].kind)
        ROW_REGS: write_regs(dir_table[i].reach, dir_table[i].fall);
        ROW_SEND: offer(dir_table[i].item);
        default: begin
          send_item(dir_table[i].item, pick_gap());
          pending_shades.push_back(dir_table[i].shade);
          n_vertices++;
          if (dir_table[i].shade.lit) n_lit++;
        end
      endcase
    end

    write_regs(DIST_W'(64'd1 << $urandom_range(20, 36)), NIB_W'($urandom));
    random_phase(PHASE_ITEMS);
    // receiver holds off for a long stretch while loads and vertices keep coming
    write_regs(DIST_MAX, FALL_MAX);
    want_hold = 1'b1;
    random_phase(PHASE_ITEMS);
    write_regs('0, '0);
    random_phase(PHASE_ITEMS);
    write_regs(DIST_W'(64'd1 << $urandom_range(1, DIST_W - 1)), NIB_W'($urandom));
    random_phase(PHASE_ITEMS);
    write_regs(DIST_W'({$urandom, $urandom}), NIB_W'($urandom));
    random_phase(PHASE_ITEMS);
    settle();

    $display("run covered %0d vertices (%0d lit), %0d loads, %0d ignored items, %0d settings",
             n_vertices, n_lit, n_loads, n_ignored, n_settings);
    $display("%0d results checked, %0d mismatches, %0d cycles", n_results, n_errors,
             cycle_count);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
